[hw/rtl/mha_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mha_pkg;

	localparam int DEF_HEAD_DIM      = 64;
	localparam int DEF_MAX_POSITIONS = 256;
	localparam int DEF_CACHE_WORDS   = 65536;
	localparam int DEF_MAX_HEADS     = 16;

	localparam logic [1:0] REG_NUM_HEADS = 2'd0;
	localparam logic [1:0] REG_KV_GROUP  = 2'd1;
	localparam logic [1:0] REG_KV_STRIDE = 2'd2;

	localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

	typedef enum logic [1:0] {
		FUNC_KEY = 2'd0,
		FUNC_VAL = 2'd1,
		FUNC_QRY = 2'd2,
		FUNC_RUN = 2'd3
	} func_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_KVH,
		ST_BASE,
		ST_SC_INIT,
		ST_SC_ISSUE,
		ST_SC_WAIT,
		ST_SC_MUL,
		ST_SC_WR,
		ST_EX_A,
		ST_EX_B,
		ST_EX_C,
		ST_NM_A,
		ST_NM_B,
		ST_NM_WAIT,
		ST_NM_WR,
		ST_VL_INIT,
		ST_VL_ISSUE,
		ST_VL_WAIT,
		ST_VL_OUT
	} state_t;

	typedef struct packed {
		logic wr_key;
		logic wr_val;
		logic wr_qry;
		logic load;
		logic kvh_step;
		logic base_set;
		logic row_init;
		logic row_next;
		logic mac_issue;
		logic mac_first;
		logic mac_last;
		logic mac_val;
		logic sc_mul;
		logic sc_wr;
		logic ex_b;
		logic ex_c;
		logic nm_start;
		logic nm_wr;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic run_ok;
		logic kvh_done;
		logic mac_done;
		logic div_done;
	} dp_sts_t;

	typedef logic [16:0] exp_tab_t [257];

	function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
		logic [63:0] n;
		logic [63:0] r;
		logic [63:0] b;
		n = n_in;
		r = '0;
		b = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (b > n) b = b >> 2;
		end
		for (int j = 0; j < 32; j++) begin
			if (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// exp(-k/16) in Q1.16, k = 0..256
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t tab;
		logic [63:0] u;
		u = 64'd1 << 32;
		for (int k = 0; k < 257; k++) begin
			tab[k] = 17'((u + 64'd32768) >> 16);
			u = (u * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
		end
		return tab;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/multi_head_attention_head_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Attention head engine for one decode step.
// Command channel: an item is taken when start is high and busy is low.
// func selects a key, value or query word write, or a run of one head.
// A write gives no result; busy stays low.
// A run with head at or above num_heads is dropped.
// A run raises busy and delivers HEAD_DIM results, one cycle each on
// out_strobe, in index order, the final one with last set; busy falls
// in the cycle that carries the final result.
// Run time grows with N = min(pos+1, MAX_POSITIONS) and HEAD_DIM; the
// serial MAC over the cache RAMs and the per-weight divide (an 18-bit
// quotient from the divider) set it.
// Results cannot be held off: the receiver must take each one as shown.
// Registers sit on an APB port: num_heads, kv_group, kv_stride.
// Reset clears control state and loads register defaults; cache contents
// are undefined until written.
module multi_head_attention_head_top import mha_pkg::*; #(
	parameter int HEAD_DIM      = DEF_HEAD_DIM,
	parameter int MAX_POSITIONS = DEF_MAX_POSITIONS,
	parameter int CACHE_WORDS   = DEF_CACHE_WORDS,
	parameter int MAX_HEADS     = DEF_MAX_HEADS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         func,
	input  wire logic [15:0]        addr,
	input  wire logic signed [15:0] data,
	input  wire logic [3:0]         head,
	input  wire logic [7:0]         pos,
	input  wire logic [15:0]        layer_offset,
	output logic                    out_strobe,
	output logic signed [15:0]      out_value,
	output logic [5:0]              out_index,
	output logic                    last
);
	localparam int IW = (HEAD_DIM > 1) ? $clog2(HEAD_DIM) : 1;
	localparam int TW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;

	logic [4:0]  num_heads_q;
	logic [4:0]  kv_group_q;
	logic [10:0] kv_stride_q;
	logic        cfg_wr;
	dp_cmd_t     cmd;
	dp_sts_t     sts;
	logic [IW-1:0] idx_i;
	logic [TW-1:0] idx_t;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_heads_q <= 5'd8;
			kv_group_q  <= 5'd1;
			kv_stride_q <= 11'd512;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_NUM_HEADS: num_heads_q <= pwdata[4:0];
				REG_KV_GROUP:  kv_group_q  <= pwdata[4:0];
				REG_KV_STRIDE: kv_stride_q <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_NUM_HEADS: prdata = 32'(num_heads_q);
			REG_KV_GROUP:  prdata = 32'(kv_group_q);
			REG_KV_STRIDE: prdata = 32'(kv_stride_q);
			default:       prdata = '0;
		endcase
	end

	mha_ctrl #(
		.HEAD_DIM     (HEAD_DIM),
		.MAX_POSITIONS(MAX_POSITIONS)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.func  (func),
		.pos   (pos),
		.sts   (sts),
		.busy  (busy),
		.cmd   (cmd),
		.idx_i (idx_i),
		.idx_t (idx_t)
	);

	mha_dp #(
		.HEAD_DIM     (HEAD_DIM),
		.MAX_POSITIONS(MAX_POSITIONS),
		.CACHE_WORDS  (CACHE_WORDS),
		.MAX_HEADS    (MAX_HEADS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.idx_i       (idx_i),
		.idx_t       (idx_t),
		.addr        (addr),
		.data        (data),
		.head        (head),
		.layer_offset(layer_offset),
		.num_heads   (num_heads_q),
		.kv_group    (kv_group_q),
		.kv_stride   (kv_stride_q),
		.sts         (sts),
		.out_strobe  (out_strobe),
		.out_value   (out_value),
		.out_index   (out_index),
		.last        (last)
	);

	a_end_of_run: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (out_strobe && last))
		else $error("run ended without final transfer");

	a_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_strobe && !last) |-> busy)
		else $error("result outside a run");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_strobe |-> (last == (out_index == 6'(HEAD_DIM - 1))))
		else $error("last flag and index disagree");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_strobe && last) |=> !out_strobe)
		else $error("transfer after final result");
endmodule
`default_nettype wire

[hw/rtl/mha_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module mha_div #(
	parameter int NW = 42,
	parameter int DW = 25,
	parameter int QW = 18
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic [QW-1:0]      quo
);
	localparam int CW = $clog2(QW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [QW-1:0] sh_q;
	logic [DW:0]   shifted;
	logic          ge;

	assign shifted = {rem_q, sh_q[QW-1]};
	assign ge      = shifted >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DW'(num[NW-1:QW]);
			sh_q  <= num[QW-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? DW'(shifted - {1'b0, den}) : DW'(shifted);
			sh_q  <= {sh_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = sh_q;
endmodule
`default_nettype wire

[hw/rtl/mha_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module mha_ctrl import mha_pkg::*; #(
	parameter int HEAD_DIM      = DEF_HEAD_DIM,
	parameter int MAX_POSITIONS = DEF_MAX_POSITIONS,
	localparam int IW = (HEAD_DIM > 1) ? $clog2(HEAD_DIM) : 1,
	localparam int TW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [1:0]    func,
	input  wire logic [7:0]    pos,
	input  wire dp_sts_t       sts,
	output logic               busy,
	output dp_cmd_t            cmd,
	output logic [IW-1:0]      idx_i,
	output logic [TW-1:0]      idx_t
);
	state_t        state_q, state_d;
	logic [IW-1:0] i_q, i_d;
	logic [TW-1:0] t_q, t_d;
	logic [TW-1:0] last_t_q, last_t_d;
	logic          i_end;
	logic          t_end;

	assign i_end = i_q == IW'(HEAD_DIM - 1);
	assign t_end = t_q == last_t_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			i_q      <= '0;
			t_q      <= '0;
			last_t_q <= '0;
		end else begin
			state_q  <= state_d;
			i_q      <= i_d;
			t_q      <= t_d;
			last_t_q <= last_t_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		i_d      = i_q;
		t_d      = t_q;
		last_t_d = last_t_q;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (func)
						FUNC_KEY: cmd.wr_key = 1'b1;
						FUNC_VAL: cmd.wr_val = 1'b1;
						FUNC_QRY: cmd.wr_qry = 1'b1;
						FUNC_RUN: begin
							if (sts.run_ok) begin
								cmd.load = 1'b1;
								last_t_d = (int'(pos) >= MAX_POSITIONS - 1) ?
									TW'(MAX_POSITIONS - 1) : TW'(pos);
								state_d  = ST_KVH;
							end
						end
						default: ;
					endcase
				end
			end
			ST_KVH: begin
				if (sts.kvh_done) state_d = ST_BASE;
				else cmd.kvh_step = 1'b1;
			end
			ST_BASE: begin
				cmd.base_set = 1'b1;
				t_d          = '0;
				state_d      = ST_SC_INIT;
			end
			ST_SC_INIT: begin
				cmd.row_init = 1'b1;
				i_d          = '0;
				state_d      = ST_SC_ISSUE;
			end
			ST_SC_ISSUE: begin
				cmd.mac_issue = 1'b1;
				cmd.mac_first = i_q == '0;
				cmd.mac_last  = i_end;
				i_d           = i_q + 1'b1;
				if (i_end) state_d = ST_SC_WAIT;
			end
			ST_SC_WAIT: begin
				if (sts.mac_done) state_d = ST_SC_MUL;
			end
			ST_SC_MUL: begin
				cmd.sc_mul = 1'b1;
				state_d    = ST_SC_WR;
			end
			ST_SC_WR: begin
				cmd.sc_wr    = 1'b1;
				cmd.row_next = 1'b1;
				i_d          = '0;
				if (t_end) begin
					t_d     = '0;
					state_d = ST_EX_A;
				end else begin
					t_d     = t_q + 1'b1;
					state_d = ST_SC_ISSUE;
				end
			end
			ST_EX_A: state_d = ST_EX_B;
			ST_EX_B: begin
				cmd.ex_b = 1'b1;
				state_d  = ST_EX_C;
			end
			ST_EX_C: begin
				cmd.ex_c = 1'b1;
				if (t_end) begin
					t_d     = '0;
					state_d = ST_NM_A;
				end else begin
					t_d     = t_q + 1'b1;
					state_d = ST_EX_A;
				end
			end
			ST_NM_A: state_d = ST_NM_B;
			ST_NM_B: begin
				cmd.nm_start = 1'b1;
				state_d      = ST_NM_WAIT;
			end
			ST_NM_WAIT: begin
				if (sts.div_done) state_d = ST_NM_WR;
			end
			ST_NM_WR: begin
				cmd.nm_wr = 1'b1;
				if (t_end) begin
					i_d     = '0;
					state_d = ST_VL_INIT;
				end else begin
					t_d     = t_q + 1'b1;
					state_d = ST_NM_A;
				end
			end
			ST_VL_INIT: begin
				cmd.row_init = 1'b1;
				t_d          = '0;
				state_d      = ST_VL_ISSUE;
			end
			ST_VL_ISSUE: begin
				cmd.mac_issue = 1'b1;
				cmd.mac_val   = 1'b1;
				cmd.mac_first = t_q == '0;
				cmd.mac_last  = t_end;
				cmd.row_next  = 1'b1;
				t_d           = t_q + 1'b1;
				if (t_end) state_d = ST_VL_WAIT;
			end
			ST_VL_WAIT: begin
				if (sts.mac_done) state_d = ST_VL_OUT;
			end
			ST_VL_OUT: begin
				cmd.emit = 1'b1;
				if (i_end) begin
					state_d = ST_IDLE;
				end else begin
					i_d     = i_q + 1'b1;
					state_d = ST_VL_INIT;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy  = state_q != ST_IDLE;
	assign idx_i = i_q;
	assign idx_t = t_q;
endmodule
`default_nettype wire

[hw/rtl/mha_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module mha_dp import mha_pkg::*; #(
	parameter int HEAD_DIM      = DEF_HEAD_DIM,
	parameter int MAX_POSITIONS = DEF_MAX_POSITIONS,
	parameter int CACHE_WORDS   = DEF_CACHE_WORDS,
	parameter int MAX_HEADS     = DEF_MAX_HEADS,
	localparam int IW = (HEAD_DIM > 1) ? $clog2(HEAD_DIM) : 1,
	localparam int TW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dp_cmd_t            cmd,
	input  wire logic [IW-1:0]      idx_i,
	input  wire logic [TW-1:0]      idx_t,
	input  wire logic [15:0]        addr,
	input  wire logic signed [15:0] data,
	input  wire logic [3:0]         head,
	input  wire logic [15:0]        layer_offset,
	input  wire logic [4:0]         num_heads,
	input  wire logic [4:0]         kv_group,
	input  wire logic [10:0]        kv_stride,
	output dp_sts_t                 sts,
	output logic                    out_strobe,
	output logic signed [15:0]      out_value,
	output logic [5:0]              out_index,
	output logic                    last
);
	localparam int CAW    = $clog2(CACHE_WORDS);
	localparam int QWORDS = MAX_HEADS * HEAD_DIM;
	localparam int QAW    = (QWORDS > 1) ? $clog2(QWORDS) : 1;
	localparam int SW     = TW + 17;
	localparam int ACC_W  = ((34 + TW > 32 + IW) ? 34 + TW : 32 + IW) + 1;
	localparam int DOT_W  = 33 + IW;
	localparam int SCL_W  = DOT_W + 18;
	localparam int NW     = SW + 17;
	localparam int DQW    = 18;
	localparam logic [63:0] SQ_ARG = (64'd1 << 32) / HEAD_DIM;
	localparam logic signed [17:0] INV_SQRT = 18'(isqrt64(SQ_ARG));
	localparam exp_tab_t EXP_TAB = build_exp_tab();

	logic signed [15:0] key_mem [CACHE_WORDS];
	logic signed [15:0] val_mem [CACHE_WORDS];
	logic signed [15:0] qry_mem [QWORDS];
	logic [31:0]        score_mem [MAX_POSITIONS];

	logic [3:0]     head_q;
	logic [15:0]    loff_q;
	logic [4:0]     rem_q;
	logic [3:0]     kvh_q;
	logic [CAW-1:0] base_q;
	logic [QAW-1:0] qbase_q;
	logic [CAW-1:0] row_q;
	logic [CAW-1:0] mac_addr;
	logic [4:0]     grp;

	logic signed [15:0] key_rd_s1, val_rd_s1, qry_rd_s1;
	logic [31:0]        score_rd_s1;
	logic               vld_s1, first_s1, last_s1, mode_s1;
	logic signed [17:0] op_a;
	logic signed [15:0] op_b;
	logic signed [33:0] prod_s2;
	logic               vld_s2, first_s2, last_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic               mac_done_q;

	logic signed [SCL_W-1:0] scl_q;
	logic signed [SCL_W-1:0] sc_sh;
	logic [SCL_W-32:0]       sc_up;
	logic signed [31:0]      sc_sat;
	logic signed [31:0]      mx_q;

	logic signed [32:0] ex_diff;
	logic               ex_zero_q;
	logic [7:0]         ex_k_q;
	logic [11:0]        ex_f_q;
	logic [16:0]        ex_ta, ex_tb, ex_d, ex_e;
	logic [29:0]        ex_m;
	logic [SW-1:0]      sum_q;

	logic [NW-1:0]  div_num;
	logic [DQW-1:0] div_quo;
	logic           div_done;

	logic               sc_wen;
	logic [31:0]        sc_wdata;
	logic signed [ACC_W-1:0] o_sh;
	logic [ACC_W-16:0]  o_up;
	logic signed [15:0] o_sat;

	logic               out_strobe_q;
	logic signed [15:0] out_value_q;
	logic [5:0]         out_index_q;
	logic               last_q;

	assign grp      = (kv_group == 5'd0) ? 5'd1 : kv_group;
	assign mac_addr = row_q + CAW'(idx_i);

	assign sts.run_ok   = ({1'b0, head} < num_heads) && (int'(head) < MAX_HEADS);
	assign sts.kvh_done = rem_q < grp;
	assign sts.mac_done = mac_done_q;
	assign sts.div_done = div_done;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			head_q <= head;
			loff_q <= layer_offset;
			rem_q  <= {1'b0, head};
			kvh_q  <= '0;
		end else if (cmd.kvh_step) begin
			rem_q <= rem_q - grp;
			kvh_q <= kvh_q + 1'b1;
		end
		if (cmd.base_set) begin
			base_q  <= CAW'(loff_q) + CAW'(kvh_q * HEAD_DIM);
			qbase_q <= QAW'(head_q * HEAD_DIM);
		end
		if (cmd.row_init) row_q <= base_q;
		else if (cmd.row_next) row_q <= row_q + CAW'(kv_stride);
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_key) key_mem[CAW'(addr)] <= data;
		key_rd_s1 <= key_mem[mac_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_val) val_mem[CAW'(addr)] <= data;
		val_rd_s1 <= val_mem[mac_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_qry) qry_mem[QAW'(addr)] <= data;
		qry_rd_s1 <= qry_mem[qbase_q + QAW'(idx_i)];
	end

	assign sc_wen = cmd.sc_wr | cmd.ex_c | cmd.nm_wr;

	always_comb begin
		if (cmd.sc_wr) sc_wdata = sc_sat;
		else if (cmd.ex_c) sc_wdata = 32'(ex_e);
		else sc_wdata = 32'(div_quo);
	end

	always_ff @(posedge clk) begin
		if (sc_wen) score_mem[idx_t] <= sc_wdata;
		score_rd_s1 <= score_mem[idx_t];
	end

	// multiply-accumulate pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			mac_done_q <= 1'b0;
		end else begin
			vld_s1     <= cmd.mac_issue;
			vld_s2     <= vld_s1;
			mac_done_q <= vld_s2 & last_s2;
		end
	end

	assign op_a = mode_s1 ? $signed({1'b0, score_rd_s1[16:0]}) : 18'(qry_rd_s1);
	assign op_b = mode_s1 ? val_rd_s1 : key_rd_s1;

	always_ff @(posedge clk) begin
		first_s1 <= cmd.mac_first;
		last_s1  <= cmd.mac_last;
		mode_s1  <= cmd.mac_val;
		prod_s2  <= op_a * op_b;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		if (vld_s2) acc_q <= first_s2 ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
	end

	// score scaling and saturation
	assign sc_sh  = scl_q >>> 16;
	assign sc_up  = sc_sh[SCL_W-1:31];
	assign sc_sat = ((&sc_up) | ~(|sc_up)) ? sc_sh[31:0] :
		(sc_sh[SCL_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff);

	always_ff @(posedge clk) begin
		if (cmd.sc_mul) scl_q <= $signed(acc_q[DOT_W-1:0]) * INV_SQRT;
		if (cmd.sc_wr && ((idx_t == '0) || (sc_sat > mx_q))) mx_q <= sc_sat;
	end

	// exp by table with linear interpolation
	assign ex_diff = {mx_q[31], mx_q} - {score_rd_s1[31], score_rd_s1};
	assign ex_ta   = EXP_TAB[ex_k_q];
	assign ex_tb   = EXP_TAB[{1'b0, ex_k_q} + 9'd1];
	assign ex_d    = ex_ta - ex_tb;
	assign ex_m    = 30'(ex_d) * 30'(ex_f_q) + 30'd2048;
	assign ex_e    = ex_zero_q ? 17'd0 : ex_ta - 17'(ex_m >> 12);

	always_ff @(posedge clk) begin
		if (cmd.ex_b) begin
			ex_zero_q <= |ex_diff[32:20];
			ex_k_q    <= ex_diff[19:12];
			ex_f_q    <= ex_diff[11:0];
		end
		if (cmd.ex_c) sum_q <= ((idx_t == '0) ? '0 : sum_q) + SW'(ex_e);
	end

	assign div_num = (NW'(score_rd_s1[16:0]) << 16) + NW'(sum_q[SW-1:1]);

	mha_div #(
		.NW(NW),
		.DW(SW),
		.QW(DQW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.nm_start),
		.num   (div_num),
		.den   (sum_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	// output rounding and saturation
	assign o_sh  = (acc_q + ACC_W'(32768)) >>> 16;
	assign o_up  = o_sh[ACC_W-1:15];
	assign o_sat = ((&o_up) | ~(|o_up)) ? o_sh[15:0] :
		(o_sh[ACC_W-1] ? 16'sh8000 : 16'sh7fff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_strobe_q <= 1'b0;
		else out_strobe_q <= cmd.emit;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_value_q <= o_sat;
			out_index_q <= 6'(idx_i);
			last_q      <= idx_i == IW'(HEAD_DIM - 1);
		end
	end

	assign out_strobe = out_strobe_q;
	assign out_value  = out_value_q;
	assign out_index  = out_index_q;
	assign last       = last_q;
endmodule
`default_nettype wire

[tb/tb_multi_head_attention_head_top.sv]
`timescale 1ns / 1ps

import mha_pkg::*;

typedef struct {
	logic signed [15:0] value;
	logic [5:0]         index;
	logic               lst;
} head_elem_t;

class attn_scoreboard;
	logic [15:0] key_mem [65536];
	logic [15:0] val_mem [65536];
	logic [15:0] qry_mem [1024];
	int unsigned n_heads;
	int unsigned group;
	int unsigned stride;
	longint      exp_lut [257];
	longint      inv_sqrt;
	head_elem_t  pending [$];
	int          errors;
	int          runs_done;
	int          runs_dropped;
	int          results_seen;

	function new();
		logic [63:0] u;
		longint r;
		n_heads = 8;
		group = 1;
		stride = 512;
		errors = 0;
		runs_done = 0;
		runs_dropped = 0;
		results_seen = 0;
		u = 64'd1 << 32;
		for (int k = 0; k < 257; k++) begin
			exp_lut[k] = longint'((u + 64'd32768) >> 16);
			u = (u * 64'd4034748382 + (64'd1 << 31)) >> 32;
		end
		r = 0;
		while ((r + 1) * (r + 1) <= (64'd1 << 32) / 64) r++;
		inv_sqrt = r;
	endfunction

	function void set_reg(logic [1:0] idx, logic [31:0] val);
		case (idx)
			REG_NUM_HEADS: n_heads = val & 31;
			REG_KV_GROUP:  group = val & 31;
			REG_KV_STRIDE: stride = val & 2047;
			default: ;
		endcase
	endfunction

	function void note(func_t f, logic [15:0] a, logic [15:0] d, logic [3:0] h,
			logic [7:0] p, logic [15:0] lo);
		longint sc [256];
		longint dot, mx, e, total, acc, v;
		int unsigned np, g, base, row;
		head_elem_t el;
		case (f)
			FUNC_KEY: key_mem[a] = d;
			FUNC_VAL: val_mem[a] = d;
			FUNC_QRY: qry_mem[a % 1024] = d;
			default: begin
				if (h >= n_heads) begin
					runs_dropped++;
					return;
				end
				runs_done++;
				np = p + 1;
				g = (group != 0) ? group : 1;
				base = lo + (h / g) * 64;
				for (int t = 0; t < np; t++) begin
					dot = 0;
					row = base + t * stride;
					for (int i = 0; i < 64; i++)
						dot += longint'($signed(qry_mem[h * 64 + i])) *
							longint'($signed(key_mem[(row + i) & 16'hFFFF]));
					dot = (dot * inv_sqrt) >>> 16;
					if (dot > 64'sd2147483647) dot = 64'sd2147483647;
					if (dot < -64'sd2147483648) dot = -64'sd2147483648;
					sc[t] = dot;
				end
				mx = sc[0];
				for (int t = 1; t < np; t++)
					if (sc[t] > mx) mx = sc[t];
				total = 0;
				for (int t = 0; t < np; t++) begin
					dot = mx - sc[t];
					if ((dot >> 12) >= 256) begin
						e = 0;
					end else begin
						e = exp_lut[dot >> 12] - (((exp_lut[dot >> 12] -
							exp_lut[(dot >> 12) + 1]) * (dot & 4095) + 2048) >> 12);
					end
					sc[t] = e;
					total += e;
				end
				if (total == 0) total = 1;
				for (int t = 0; t < np; t++)
					sc[t] = (sc[t] * 65536 + total / 2) / total;
				for (int i = 0; i < 64; i++) begin
					acc = 0;
					for (int t = 0; t < np; t++)
						acc += sc[t] * longint'($signed(
							val_mem[(base + t * stride + i) & 16'hFFFF]));
					v = (acc + 32768) >>> 16;
					if (v > 32767) v = 32767;
					if (v < -32768) v = -32768;
					el.value = v[15:0];
					el.index = i[5:0];
					el.lst = (i == 63);
					pending.push_back(el);
				end
			end
		endcase
	endfunction

	function void check(logic signed [15:0] v, logic [5:0] idx, logic lst);
		head_elem_t el;
		results_seen++;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result value %0d index %0d last %0d",
				$time, v, idx, lst);
			errors++;
			return;
		end
		el = pending.pop_front();
		if (v !== el.value) begin
			$display("%0t: out_value expected %0d actual %0d", $time, el.value, v);
			errors++;
		end
		if (idx !== el.index) begin
			$display("%0t: out_index expected %0d actual %0d", $time, el.index, idx);
			errors++;
		end
		if (lst !== el.lst) begin
			$display("%0t: last expected %0d actual %0d", $time, el.lst, lst);
			errors++;
		end
	endfunction
endclass

module tb_multi_head_attention_head_top;
	localparam int STALL_LIMIT = 200000;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [3:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               start;
	logic               busy;
	logic [1:0]         func;
	logic [15:0]        addr;
	logic signed [15:0] data;
	logic [3:0]         head;
	logic [7:0]         pos;
	logic [15:0]        layer_offset;
	logic               out_strobe;
	logic signed [15:0] out_value;
	logic [5:0]         out_index;
	logic               last;

	attn_scoreboard sb;
	bit  key_ok [65536];
	bit  val_ok [65536];
	bit  qry_ok [1024];
	bit  gaps_on;
	int  progress;
	int  seen_progress;
	int  stall_cycles;

	multi_head_attention_head_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.addr         (addr),
		.data         (data),
		.head         (head),
		.pos          (pos),
		.layer_offset (layer_offset),
		.out_strobe   (out_strobe),
		.out_value    (out_value),
		.out_index    (out_index),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk) begin
		if (arst_n && out_strobe) begin
			sb.check(out_value, out_index, last);
			progress++;
		end
	end

	always @(posedge clk) begin
		if (progress != seen_progress) begin
			seen_progress = progress;
			stall_cycles = 0;
		end else if (arst_n) begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb_multi_head_attention_head_top failed");
				$finish;
			end
		end
	end

	task automatic issue(func_t f, logic [15:0] a, logic [15:0] d, logic [3:0] h,
			logic [7:0] p, logic [15:0] lo);
		logic b;
		start <= 1'b1;
		func <= f;
		addr <= a;
		data <= d;
		head <= h;
		pos <= p;
		layer_offset <= lo;
		do begin
			@(negedge clk);
			b = busy;
			@(posedge clk);
		end while (b);
		sb.note(f, a, d, h, p, lo);
		case (f)
			FUNC_KEY: key_ok[a] = 1'b1;
			FUNC_VAL: val_ok[a] = 1'b1;
			FUNC_QRY: qry_ok[a % 1024] = 1'b1;
			default: ;
		endcase
		progress++;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic rand_write();
		func_t f;
		f = func_t'($urandom_range(0, 2));
		issue(f, 16'($urandom), 16'($urandom), 4'($urandom), 8'($urandom),
			16'($urandom));
	endtask

	// every word the run reads must have been written first
	task automatic run_head(logic [3:0] h, logic [7:0] p, logic [15:0] lo);
		int unsigned g;
		logic [15:0] a;
		if (h < sb.n_heads) begin
			g = (sb.group != 0) ? sb.group : 1;
			for (int i = 0; i < 64; i++)
				if (!qry_ok[h * 64 + i])
					issue(FUNC_QRY, 16'(h * 64 + i), 16'($urandom), 4'($urandom),
						8'($urandom), 16'($urandom));
			for (int t = 0; t <= p; t++)
				for (int i = 0; i < 64; i++) begin
					a = 16'(lo + t * sb.stride + (h / g) * 64 + i);
					if (!key_ok[a])
						issue(FUNC_KEY, a, 16'($urandom), 4'($urandom), 8'($urandom),
							16'($urandom));
					if (!val_ok[a])
						issue(FUNC_VAL, a, 16'($urandom), 4'($urandom), 8'($urandom),
							16'($urandom));
				end
		end
		issue(FUNC_RUN, 16'($urandom), 16'($urandom), h, p, lo);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (sb.pending.size() != 0 || busy);
		repeat (10) @(posedge clk);
	endtask

	task automatic apb_write(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic set_config(int unsigned nh, int unsigned grp, int unsigned str);
		apb_write(REG_NUM_HEADS, nh);
		apb_write(REG_KV_GROUP, grp);
		apb_write(REG_KV_STRIDE, str);
	endtask

	task automatic random_phase(int n);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 9) < 4)
				run_head(4'($urandom), ($urandom_range(0, 9) == 0) ?
					8'($urandom_range(8, 40)) : 8'($urandom_range(0, 7)),
					16'($urandom));
			else
				rand_write();
		end
	endtask

	initial begin
		sb = new();
		progress = 0;
		seen_progress = 0;
		stall_cycles = 0;
		gaps_on = 1'b1;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		func = FUNC_KEY;
		addr = '0;
		data = '0;
		head = '0;
		pos = '0;
		layer_offset = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, wraps, dropped heads, at reset defaults
		issue(FUNC_KEY, 16'hFFFF, 16'h7FFF, 4'h0, 8'h00, 16'h0000);
		issue(FUNC_VAL, 16'h0000, 16'h8000, 4'hF, 8'hFF, 16'hFFFF);
		issue(FUNC_QRY, 16'hFFFF, 16'h8000, 4'h0, 8'h00, 16'h0000);
		for (int i = 0; i < 64; i++) begin
			issue(FUNC_QRY, 16'(i), 16'h7FFF, 4'h0, 8'h00, 16'h0000);
			issue(FUNC_KEY, 16'(i), 16'h7FFF, 4'h0, 8'h00, 16'h0000);
			issue(FUNC_VAL, 16'(i), 16'h8000, 4'h0, 8'h00, 16'h0000);
		end
		run_head(4'd0, 8'd0, 16'h0000);
		run_head(4'd8, 8'd3, 16'h0000);
		run_head(4'd7, 8'd3, 16'hFFF0);
		run_head(4'd15, 8'd0, 16'h0000);
		drain();

		set_config(16, 0, 1);
		run_head(4'd15, 8'd2, 16'hFFFF);
		run_head(4'd9, 8'd1, 16'h8000);
		drain();

		set_config(1, 16, 1024);
		run_head(4'd0, 8'd255, 16'h1234);
		run_head(4'd1, 8'd0, 16'h0000);
		drain();

		set_config(0, 1, 512);
		run_head(4'd0, 8'd0, 16'h0000);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			set_config($urandom_range(1, 16), $urandom_range(1, 16),
				$urandom_range(1, 1024));
			if (ph == 2) gaps_on = 1'b0;
			random_phase(35);
			drain();
		end

		$display("covered %0d runs (%0d dropped), %0d results, key/query/value writes",
			sb.runs_done, sb.runs_dropped, sb.results_seen);
		$display("register settings at and between the extremes, %0d mismatches",
			sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("tb_multi_head_attention_head_top passed");
		end else begin
			$display("tb_multi_head_attention_head_top failed");
		end
		$finish;
	end
endmodule
